// ----- design/morse_character_keyer_unit_defines.svh -----
// ---------------------------------------------------------------------------
// Morse character keyer assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef MORSE_CHARACTER_KEYER_UNIT_DEFINES_SVH
`define MORSE_CHARACTER_KEYER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCK_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MCK_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/mck_pkg.sv -----
// ---------------------------------------------------------------------------
// Morse character keyer package
// Widths, the packed Morse table, segment kinds and controller/datapath types.
// ---------------------------------------------------------------------------
package mck_pkg;

   localparam int unsigned CharWidth  = 8;
   localparam int unsigned UnitWidth  = 8;
   localparam int unsigned UnitsWidth = 2;
   localparam int unsigned TicksWidth = 10;
   localparam int unsigned PatWidth   = 6;
   localparam int unsigned CountWidth = 3;
   localparam int unsigned TableSize  = 43;
   localparam int unsigned TableIdxW  = 6;

   localparam logic [UnitWidth-1:0] UnitLengthReset = 8'd20;

   localparam logic [CharWidth-1:0] CharDash   = 8'd45;
   localparam logic [CharWidth-1:0] CharDot    = 8'd46;
   localparam logic [CharWidth-1:0] TableFirst = 8'd48;
   localparam logic [CharWidth-1:0] TableLast  = 8'd90;

   localparam logic [CountWidth-1:0] PuncCount   = 3'd6;
   localparam logic [PatWidth-1:0]   DashPattern = 6'h21;
   localparam logic [PatWidth-1:0]   DotPattern  = 6'h15;

   localparam logic [UnitsWidth-1:0] UnitsDit   = 2'd1;
   localparam logic [UnitsWidth-1:0] UnitsClose = 2'd2;
   localparam logic [UnitsWidth-1:0] UnitsDah   = 2'd3;

   // Low three bits give the element count, the bits above give the elements,
   // first element most significant, a one meaning dah.
   localparam logic [7:0] MorseTable [0:TableSize-1] = '{
      8'hFD, 8'h7D, 8'h3D, 8'h1D, 8'h0D, 8'h05, 8'h85, 8'hC5, 8'hE5, 8'hF5,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h0A, 8'h44, 8'h54, 8'h23, 8'h01, 8'h14, 8'h33, 8'h04, 8'h02, 8'h3C,
      8'h2B, 8'h24, 8'h1A, 8'h12, 8'h3B, 8'h34, 8'h6C, 8'h13, 8'h03, 8'h09,
      8'h0B, 8'h0C, 8'h1B, 8'h4C, 8'h5C, 8'h64
   };

   typedef struct packed {
      logic [CountWidth-1:0] count;
      logic [PatWidth-1:0]   pattern;
   } mck_code_type;

   typedef enum logic [1:0] {
      SEG_TONE  = 2'd0,
      SEG_GAP   = 2'd1,
      SEG_CLOSE = 2'd2
   } mck_seg_type;

   typedef struct packed {
      logic        load_char;
      logic        load_seg;
      mck_seg_type seg;
   } mck_cmd_type;

   typedef struct packed {
      logic new_empty;
      logic count_zero;
   } mck_sts_type;

   function automatic mck_code_type mck_lookup(input logic [CharWidth-1:0] c);
      mck_code_type           code;
      logic [7:0]             entry;
      logic [TableIdxW-1:0]   idx;
      code  = '0;
      idx   = TableIdxW'(c - TableFirst);
      entry = MorseTable[idx];
      if (c == CharDash) begin
         code.count   = PuncCount;
         code.pattern = DashPattern;
      end else if (c == CharDot) begin
         code.count   = PuncCount;
         code.pattern = DotPattern;
      end else if (c >= TableFirst && c <= TableLast) begin
         code.count   = entry[2:0];
         code.pattern = {1'b0, entry[7:3]};
      end
      return code;
   endfunction

endpackage

// ----- design/mck_intf.sv -----
// ---------------------------------------------------------------------------
// Morse character keyer channel interfaces
// Valid/ready channels for characters, segments and the unit length write.
// ---------------------------------------------------------------------------
interface mck_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;
   modport source (output valid, output character, input ready);
   modport sink   (input valid, input character, output ready);
endinterface

interface mck_rsp_if;
   logic       valid;
   logic       ready;
   logic       tone_on;
   logic [1:0] length_units;
   logic [9:0] length_ticks;
   logic       last_segment;
   modport source (output valid, output tone_on, output length_units,
                   output length_ticks, output last_segment, input ready);
   modport sink   (input valid, input tone_on, input length_units,
                   input length_ticks, input last_segment, output ready);
endinterface

interface mck_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- design/mck_datapath.sv -----
// ---------------------------------------------------------------------------
// Morse character keyer datapath
// Holds the unit length, the element pattern and the segment output register.
// ---------------------------------------------------------------------------
module mck_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mck_pkg::mck_cmd_type                 cmd,
   output mck_pkg::mck_sts_type                 sts,
   input  logic [mck_pkg::CharWidth-1:0]        character,
   input  logic                                 csr_we,
   input  logic [mck_pkg::UnitWidth-1:0]        csr_data,
   output logic                                 tone_on,
   output logic [mck_pkg::UnitsWidth-1:0]       length_units,
   output logic [mck_pkg::TicksWidth-1:0]       length_ticks,
   output logic                                 last_segment
);
   import mck_pkg::*;

   logic [UnitWidth-1:0]  unit_ff, unit_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [PatWidth-1:0]   pattern_ff, pattern_in;
   logic                  tone_ff, tone_in;
   logic [UnitsWidth-1:0] units_ff, units_in;
   logic [TicksWidth-1:0] ticks_ff, ticks_in;
   logic                  last_ff, last_in;
   mck_code_type          code;
   logic                  dah;

   assign code = mck_lookup(character);
   assign dah  = pattern_ff[count_ff - 3'd1];

   always_comb begin
      unit_in    = csr_we ? csr_data : unit_ff;
      count_in   = count_ff;
      pattern_in = pattern_ff;
      tone_in    = tone_ff;
      units_in   = units_ff;
      last_in    = last_ff;
      if (cmd.load_char) begin
         count_in   = code.count;
         pattern_in = code.pattern;
      end
      if (cmd.load_seg) begin
         case (cmd.seg)
            SEG_TONE: begin
               tone_in  = 1'b1;
               units_in = dah ? UnitsDah : UnitsDit;
               last_in  = 1'b0;
               count_in = count_ff - 3'd1;
            end
            SEG_GAP: begin
               tone_in  = 1'b0;
               units_in = UnitsDit;
               last_in  = 1'b0;
            end
            default: begin
               tone_in  = 1'b0;
               units_in = UnitsClose;
               last_in  = 1'b1;
            end
         endcase
      end
   end

   // Ticks are the unit length times one, two or three: shifts and one add.
   always_comb begin
      case (units_in)
         UnitsDit:   ticks_in = {2'b00, unit_ff};
         UnitsClose: ticks_in = {1'b0, unit_ff, 1'b0};
         UnitsDah:   ticks_in = {2'b00, unit_ff} + {1'b0, unit_ff, 1'b0};
         default:    ticks_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff <= UnitLengthReset;
      end else begin
         unit_ff <= unit_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff   <= count_in;
      pattern_ff <= pattern_in;
      tone_ff    <= tone_in;
      units_ff   <= units_in;
      last_ff    <= last_in;
      if (cmd.load_seg) begin
         ticks_ff <= ticks_in;
      end
   end

   assign sts.new_empty  = (code.count == 3'd0);
   assign sts.count_zero = (count_ff == 3'd0);

   assign tone_on      = tone_ff;
   assign length_units = units_ff;
   assign length_ticks = ticks_ff;
   assign last_segment = last_ff;

endmodule

// ----- design/mck_controller.sv -----
// ---------------------------------------------------------------------------
// Morse character keyer controller
// Sequences tone, element gap and closing gap segments, owns output valid.
// ---------------------------------------------------------------------------
`include "morse_character_keyer_unit_defines.svh"

module mck_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output mck_pkg::mck_cmd_type  cmd,
   input  mck_pkg::mck_sts_type  sts
);
   import mck_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_TONE  = 4'b0010,
      ST_GAP   = 4'b0100,
      ST_CLOSE = 4'b1000
   } mck_state_type;

   mck_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept;
   logic          slot_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      cmd.load_char = 1'b0;
      cmd.load_seg  = 1'b0;
      cmd.seg       = SEG_CLOSE;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load_char = 1'b1;
               state_in      = sts.new_empty ? ST_CLOSE : ST_TONE;
            end
         end
         ST_TONE: begin
            cmd.seg = SEG_TONE;
            if (slot_free) begin
               cmd.load_seg = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_GAP;
            end
         end
         ST_GAP: begin
            cmd.seg = SEG_GAP;
            if (slot_free) begin
               cmd.load_seg = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = sts.count_zero ? ST_CLOSE : ST_TONE;
            end
         end
         ST_CLOSE: begin
            cmd.seg = SEG_CLOSE;
            if (slot_free) begin
               cmd.load_seg = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `MCK_ASSERT_NEXT(a_accept_leaves_idle, accept, state_ff != ST_IDLE, "accept did not start sequence")
   `MCK_ASSERT_NEXT(a_close_ends_char, state_ff == ST_CLOSE && slot_free, state_ff == ST_IDLE && rsp_valid_ff, "closing gap did not end character")
   `MCK_ASSERT_NEXT(a_stall_freezes, state_ff != ST_IDLE && rsp_valid_ff && !rsp_ready, $stable(state_ff), "sequencer moved during stall")
   `MCK_ASSERT_SAME(a_no_seg_idle, state_ff == ST_IDLE, !cmd.load_seg, "segment loaded while idle")

endmodule

// ----- design/morse_character_keyer_unit.sv -----
// ---------------------------------------------------------------------------
// Morse character keyer unit
// Turns one ASCII character into its Morse keying as a run of segments.
// ---------------------------------------------------------------------------
// The req_ch channel takes one character per word. Digits, upper-case letters,
// '-' and '.' are keyed; any other code yields only the closing gap.
// The rsp_ch channel returns one segment per word: tone flag, length in units,
// length in ticks (units times the unit length) and a last mark set on the
// closing two-unit gap. Each element gives a tone segment and a one-unit gap.
// The csr_ch channel writes the 8-bit unit length, which is always ready and
// should only be written while no character is in flight.
// A character with n elements yields 2n+1 segments. Once the character is
// accepted, the sequencer moves to its tone or closing state and from there
// loads one segment per cycle while the receiver does not stall; a character
// has at most six elements.
// The sequencer emits each segment into a single output register. A new
// character is accepted once the closing gap has been loaded, even while
// that segment still waits to be taken.
// When the receiver stalls, the output register holds its segment and the
// sequencer waits. Reset is synchronous and active high; it empties the output
// register, returns the sequencer to idle and sets the unit length to 20.
// ---------------------------------------------------------------------------
module morse_character_keyer_unit (
   input logic        clock,
   input logic        reset,
   mck_req_if.sink    req_ch,
   mck_rsp_if.source  rsp_ch,
   mck_csr_if.sink    csr_ch
);
   import mck_pkg::*;

   mck_cmd_type cmd;
   mck_sts_type sts;

   // The unit length register takes every write at once.
   assign csr_ch.ready = 1'b1;

   // The controller owns the handshakes and the segment order.
   mck_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // The datapath looks up the character and forms each segment word.
   mck_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .character    (req_ch.character),
      .csr_we       (csr_ch.valid),
      .csr_data     (csr_ch.data),
      .tone_on      (rsp_ch.tone_on),
      .length_units (rsp_ch.length_units),
      .length_ticks (rsp_ch.length_ticks),
      .last_segment (rsp_ch.last_segment)
   );

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Morse character keyer testbench
// Feeds characters into the keyer, predicts every keyed segment on its own
// and compares each segment word that comes back, over several unit lengths
// and with random idling on both the character and the segment channels.
// ---------------------------------------------------------------------------
module tb_top;
   import mck_pkg::*;

   // The run stops here even if the keyer hangs.
   localparam int unsigned CycleLimit = 400000;
   localparam int unsigned DrainCycles = 20;
   localparam int unsigned IdleMax = 17;

   // Element codes for the digits and upper-case letters, one byte per
   // character starting at '0'. The low three bits hold the element count
   // and the bits above hold the elements, first element highest, one = dah.
   // The seven codes between '9' and 'A' have no elements.
   localparam int unsigned CodeCount = 43;
   localparam logic [8*CodeCount-1:0] ElementCodes = {
      8'hFD, 8'h7D, 8'h3D, 8'h1D, 8'h0D, 8'h05, 8'h85, 8'hC5, 8'hE5, 8'hF5,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h0A, 8'h44, 8'h54, 8'h23, 8'h01, 8'h14, 8'h33, 8'h04, 8'h02, 8'h3C,
      8'h2B, 8'h24, 8'h1A, 8'h12, 8'h3B, 8'h34, 8'h6C, 8'h13, 8'h03, 8'h09,
      8'h0B, 8'h0C, 8'h1B, 8'h4C, 8'h5C, 8'h64
   };

   // Element patterns of the two punctuation marks, first element highest.
   localparam logic [5:0] HyphenElements = 6'b100001;
   localparam logic [5:0] PeriodElements = 6'b010101;

   // The opening directed characters: both ends of the byte, digits with
   // five elements, one-element letters, the longest letters, both
   // punctuation marks and a spread of codes that key nothing.
   localparam int unsigned OpeningCount = 22;
   localparam logic [8*OpeningCount-1:0] OpeningChars = {
      8'd0, 8'd255, "0", "9", "5", ":", "@", "A", "Z", "E", "T",
      "Q", "[", "-", ".", "/", ",", "a", "z", 8'h7F, 8'h80, "Y"
   };

   typedef struct packed {
      logic                  tone_on;
      logic [UnitsWidth-1:0] length_units;
      logic [TicksWidth-1:0] length_ticks;
      logic                  last_segment;
   } segment_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // Every channel input of the keyer is driven from these, so each has a known
   // value from time zero.
   logic                 req_valid_r = 1'b0;
   logic [CharWidth-1:0] req_char_r  = '0;
   logic                 rsp_ready_r = 1'b0;
   logic                 csr_valid_r = 1'b0;
   logic [UnitWidth-1:0] csr_data_r  = '0;

   mck_req_if req_if ();
   mck_rsp_if rsp_if ();
   mck_csr_if csr_if ();

   assign req_if.valid     = req_valid_r;
   assign req_if.character = req_char_r;
   assign rsp_if.ready     = rsp_ready_r;
   assign csr_if.valid     = csr_valid_r;
   assign csr_if.data      = csr_data_r;

   morse_character_keyer_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Characters waiting to be offered, and the segments that the keyer still
   // owes for the characters that it has taken.
   logic [CharWidth-1:0] pending_chars [$];
   segment_type          expected_segs [$];

   // Our copy of the unit length register, updated when a write is taken.
   logic [UnitWidth-1:0] unit_length_copy = UnitLengthReset;

   int unsigned error_count   = 0;
   int unsigned segment_count = 0;
   int unsigned cycle_count   = 0;

   // Character side state. While char_held is set, req_valid_r is high and
   // held_char sits on the channel.
   logic                 char_held     = 1'b0;
   logic [CharWidth-1:0] held_char     = '0;
   int unsigned          req_idle_left = 0;
   bit                   req_calm      = 1'b0;

   // Segment side state.
   int unsigned rsp_stall_left = 0;
   bit          rsp_calm       = 1'b0;

   // Builds one segment word as the keyer should present it. The tick count
   // is the unit count times the unit length, cut to the field width.
   function automatic segment_type make_segment(input logic tone,
                                                input logic [UnitsWidth-1:0] units,
                                                input logic last);
      segment_type seg;
      seg.tone_on      = tone;
      seg.length_units = units;
      seg.length_ticks = TicksWidth'(units) * TicksWidth'(unit_length_copy);
      seg.last_segment = last;
      return seg;
   endfunction

   // Appends the full keying of one character to the expected segments: a
   // tone and a one-unit gap per element, then the closing two-unit gap.
   // A character without elements gives the closing gap alone.
   function automatic void queue_keying(input logic [CharWidth-1:0] ch);
      logic [7:0]  code;
      logic [2:0]  count;
      logic [5:0]  elements;
      int unsigned slot;
      count    = '0;
      elements = '0;
      if (ch == CharDash) begin
         count    = PuncCount;
         elements = HyphenElements;
      end else if (ch == CharDot) begin
         count    = PuncCount;
         elements = PeriodElements;
      end else if (ch >= TableFirst && ch <= TableLast) begin
         slot     = ch - TableFirst;
         code     = ElementCodes[(CodeCount - 1 - slot) * 8 +: 8];
         count    = code[2:0];
         elements = {1'b0, code[7:3]};
      end
      for (int i = count; i > 0; i--) begin
         expected_segs.push_back(make_segment(1'b1,
                                              elements[i-1] ? UnitsDah : UnitsDit,
                                              1'b0));
         expected_segs.push_back(make_segment(1'b0, UnitsDit, 1'b0));
      end
      expected_segs.push_back(make_segment(1'b0, UnitsClose, 1'b1));
   endfunction

   // Mostly characters that key something, with the rest drawn from the
   // whole byte so that every code and every bit is reached.
   function automatic logic [CharWidth-1:0] pick_character();
      int unsigned pick;
      if ($urandom_range(0, 9) < 8) begin
         pick = $urandom_range(0, 37);
         if (pick < 10) return CharWidth'("0" + pick);
         if (pick < 36) return CharWidth'("A" + pick - 10);
         if (pick == 36) return CharDash;
         return CharDot;
      end
      return CharWidth'($urandom_range(0, 255));
   endfunction

   // Prints one line per mismatch and counts every one of them.
   task automatic report_mismatch(input string what);
      $display("segment %0d: %s", segment_count, what);
      error_count++;
   endtask

   // Character driver. A taken word clears char_held; the next character is
   // offered in the same cycle if no idle cycles were drawn, so the valid
   // gets a single assignment per edge and never drops between items.
   always @(posedge clock) begin
      if (reset) begin
         char_held   = 1'b0;
         req_valid_r <= 1'b0;
      end else begin
         if (char_held && req_if.ready) begin
            queue_keying(held_char);
            char_held = 1'b0;
            if ($urandom_range(0, 39) == 0)
               req_calm = !req_calm;
            req_idle_left = req_calm ? 0 : $urandom_range(0, IdleMax);
         end
         if (!char_held) begin
            if (req_idle_left == 0 && pending_chars.size() != 0) begin
               held_char  = pending_chars.pop_front();
               char_held  = 1'b1;
               req_char_r <= held_char;
            end else if (req_idle_left != 0) begin
               req_idle_left--;
            end
         end
         req_valid_r <= char_held;
      end
   end

   // Segment monitor. Each taken word is checked field by field against the
   // oldest expected segment, and a fresh stall is drawn for the next word.
   always @(posedge clock) begin
      segment_type want;
      if (reset) begin
         rsp_stall_left = 0;
         rsp_ready_r    <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_ready_r) begin
            if (expected_segs.size() == 0) begin
               report_mismatch("segment word arrived with none expected");
            end else begin
               want = expected_segs.pop_front();
               if (rsp_if.tone_on !== want.tone_on)
                  report_mismatch($sformatf("tone_on %b, expected %b",
                                            rsp_if.tone_on, want.tone_on));
               if (rsp_if.length_units !== want.length_units)
                  report_mismatch($sformatf("length_units %0d, expected %0d",
                                            rsp_if.length_units, want.length_units));
               if (rsp_if.length_ticks !== want.length_ticks)
                  report_mismatch($sformatf("length_ticks %0d, expected %0d",
                                            rsp_if.length_ticks, want.length_ticks));
               if (rsp_if.last_segment !== want.last_segment)
                  report_mismatch($sformatf("last_segment %b, expected %b",
                                            rsp_if.last_segment, want.last_segment));
            end
            segment_count++;
            if ($urandom_range(0, 39) == 0)
               rsp_calm = !rsp_calm;
            rsp_stall_left = rsp_calm ? 0 : $urandom_range(0, IdleMax);
         end else if (rsp_stall_left != 0) begin
            rsp_stall_left--;
         end
         rsp_ready_r <= (rsp_stall_left == 0);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Returns once every character has been taken and every segment that it
   // caused has come back, so the keyer is idle.
   task automatic wait_for_idle();
      while (pending_chars.size() != 0 || char_held || expected_segs.size() != 0)
         @(posedge clock);
   endtask

   // Writes the unit length through the register channel, which is only done
   // while the keyer is idle. Our copy changes once the word is taken.
   task automatic write_unit_length(input logic [UnitWidth-1:0] value);
      @(posedge clock);
      csr_valid_r <= 1'b1;
      csr_data_r  <= value;
      do
         @(posedge clock);
      while (!csr_if.ready);
      csr_valid_r      <= 1'b0;
      unit_length_copy = value;
   endtask

   task automatic queue_random_chars(input int unsigned n);
      repeat (n)
         pending_chars.push_back(pick_character());
   endtask

   initial begin
      // Synchronous reset, active high from time zero until released.
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed characters at the unit length that reset leaves.
      for (int i = OpeningCount - 1; i >= 0; i--)
         pending_chars.push_back(OpeningChars[i*8 +: 8]);
      wait_for_idle();

      // The shortest unit, then the longest, where the dah tick count reaches
      // its largest value, 765.
      write_unit_length(8'd1);
      queue_random_chars(40);
      wait_for_idle();

      write_unit_length(8'd255);
      queue_random_chars(40);
      wait_for_idle();

      // A zero unit length is passed through, so every tick count is zero.
      write_unit_length(8'd0);
      queue_random_chars(20);
      wait_for_idle();

      write_unit_length(UnitWidth'($urandom_range(1, 255)));
      queue_random_chars(40);
      wait_for_idle();

      write_unit_length(8'd3);
      queue_random_chars(50);
      wait_for_idle();

      // Give the keyer time to show any stray segment word.
      repeat (DrainCycles) @(posedge clock);

      if (error_count == 0 && expected_segs.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+design
design/mck_pkg.sv
design/mck_intf.sv
design/mck_datapath.sv
design/mck_controller.sv
design/morse_character_keyer_unit.sv
sim/tb_top.sv
